// File: hdl/tcgb_pkg.sv
// ----------------------------------------------------------------------------
// tcgb_pkg
// Types and constants shared by the column gap boundary finder.
// ----------------------------------------------------------------------------
package tcgb_pkg;

  localparam int XW      = 20;  // glyph left edge
  localparam int WW      = 16;  // glyph advance width
  localparam int EW      = 21;  // glyph right edge
  localparam int BW      = 22;  // boundary, 1/32 point
  localparam int IW      = 6;   // boundary ordinal
  localparam int TOLW    = 12;  // tolerance register
  localparam int MAX_OUT = 64;  // results per run
  localparam int QDEPTH  = 4;
  localparam int QAW     = 2;

  localparam logic [TOLW-1:0] TOL_RESET = 12'd16;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef enum logic {
    FS_IDLE,
    FS_DRAIN
  } front_state_t;

  typedef enum logic [1:0] {
    TOK_EMPTY,
    TOK_HEAD,
    TOK_MID,
    TOK_TAIL
  } tok_kind_t;

  typedef struct packed {
    logic            func;
    logic [XW-1:0]   glyph_x;
    logic [WW-1:0]   glyph_width;
  } tcgb_in_t;

  typedef struct packed {
    logic [BW-1:0]   boundary;
    logic [IW-1:0]   boundary_index;
    logic            last;
    logic            empty_res;
    logic            dropped;
  } tcgb_out_t;

  typedef struct packed {
    tok_kind_t       kind;
    logic            dropped;
    logic [XW-1:0]   start;
    logic [EW-1:0]   span_end;
  } tcgb_tok_t;

endpackage

// File: hdl/text_column_gap_boundary_finder.sv
// ----------------------------------------------------------------------------
// text_column_gap_boundary_finder
// Collects glyph spans in sorted order and emits column boundaries on finish.
// ----------------------------------------------------------------------------
// On a load item, the span is placed into its sorted position in
// the cell row at once, and busy stays low. A finish item holds busy high while
// the cell row drains one span a cycle into the token queue, unless it is full,
// and then a tail or empty token. Each result is registered behind the token
// queue and the s1 stage, at most one per cycle, each for a single cycle
// marked by strobe; the receiver must take every result as it comes. Loads
// for the next run may start as soon as busy falls.
module text_column_gap_boundary_finder #(
  parameter int MAX_GLYPHS = 63
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tcgb_pkg::tcgb_in_t            cmd,
  input  logic                          cfg_wr,
  input  logic [tcgb_pkg::TOLW-1:0]     cfg_wdata,
  output logic                          strobe,
  output tcgb_pkg::tcgb_out_t           result
);
  import tcgb_pkg::*;

  localparam int CW   = $clog2(MAX_GLYPHS + 1);
  localparam int TW   = WW + CW;
  localparam int TOKW = $bits(tcgb_tok_t);
  localparam int QW   = TOKW + CW + TW;

  logic [TOLW-1:0] tolerance;
  tcgb_tok_t       f_tok, q_tok;
  logic [CW-1:0]   f_count, q_count;
  logic [TW-1:0]   f_total, q_total;
  logic            f_push, q_full, q_pop, q_nonempty;
  logic [QW-1:0]   q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_wr) begin
      tolerance <= cfg_wdata;
    end
  end

  tcgb_front #(
    .MAX_GLYPHS (MAX_GLYPHS),
    .CW         (CW),
    .TW         (TW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .push      (f_push),
    .full      (q_full),
    .tok       (f_tok),
    .run_count (f_count),
    .run_total (f_total)
  );

  tcgb_queue #(
    .W (QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .wdata    ({f_tok, f_count, f_total}),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .nonempty (q_nonempty)
  );

  assign {q_tok, q_count, q_total} = q_rdata;

  tcgb_back #(
    .CW (CW),
    .TW (TW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .valid     (q_nonempty),
    .pop       (q_pop),
    .tok       (q_tok),
    .run_count (q_count),
    .run_total (q_total),
    .tolerance (tolerance),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

// File: hdl/tcgb_front.sv
// ----------------------------------------------------------------------------
// tcgb_front
// Accepts items, keeps glyph spans sorted by start then end in a row of
// cells, and on finish drains them as tokens toward the back end.
// ----------------------------------------------------------------------------
module tcgb_front #(
  parameter int MAX_GLYPHS = 63,
  parameter int CW         = 6,
  parameter int TW         = 22
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tcgb_pkg::tcgb_in_t  cmd,
  output logic                push,
  input  logic                full,
  output tcgb_pkg::tcgb_tok_t tok,
  output logic [CW-1:0]       run_count,
  output logic [TW-1:0]       run_total
);
  import tcgb_pkg::*;

  logic [XW-1:0]   span_start [MAX_GLYPHS];
  logic [EW-1:0]   span_end   [MAX_GLYPHS];
  logic [CW-1:0]   count;
  logic [TW-1:0]   total;
  logic            overflow_seen;
  logic            run_drop;
  logic [EW-1:0]   last_end;
  front_state_t    state, state_next;

  logic            accept, load, finish, can_ins, insert, span_out;
  logic [EW-1:0]   new_end;
  logic [MAX_GLYPHS-1:0] lt;

  assign busy    = (state == FS_DRAIN);
  assign accept  = start && !busy;
  assign load    = accept && (cmd.func == FUNC_LOAD);
  assign finish  = accept && (cmd.func == FUNC_FINISH);
  assign can_ins = (count < CW'(MAX_GLYPHS));
  assign insert  = load && can_ins;
  assign new_end = EW'(cmd.glyph_x) + EW'(cmd.glyph_width);

  always_comb begin
    for (int j = 0; j < MAX_GLYPHS; j++) begin
      lt[j] = (CW'(j) >= count) ||
              ({1'b0, cmd.glyph_x} < {1'b0, span_start[j]}) ||
              ((cmd.glyph_x == span_start[j]) && (new_end < span_end[j]));
    end
  end

  for (genvar j = 0; j < MAX_GLYPHS; j++) begin : g_cell
    logic take_new, take_prev;
    if (j == 0) begin : g_first
      assign take_new  = lt[0];
      assign take_prev = 1'b0;
    end else begin : g_rest
      assign take_new  = lt[j] && !lt[j-1];
      assign take_prev = lt[j-1];
    end
    always_ff @(posedge clk) begin
      if (insert) begin
        if (take_prev) begin
          span_start[j] <= span_start[(j > 0) ? j - 1 : 0];
          span_end[j]   <= span_end[(j > 0) ? j - 1 : 0];
        end else if (take_new) begin
          span_start[j] <= cmd.glyph_x;
          span_end[j]   <= new_end;
        end
      end else if (span_out) begin
        if (j < MAX_GLYPHS - 1) begin
          span_start[j] <= span_start[(j < MAX_GLYPHS - 1) ? j + 1 : j];
          span_end[j]   <= span_end[(j < MAX_GLYPHS - 1) ? j + 1 : j];
        end
      end
    end
  end

  always_comb begin
    state_next    = state;
    push          = 1'b0;
    span_out      = 1'b0;
    tok.dropped   = run_drop;
    tok.start     = span_start[0];
    tok.span_end  = span_end[0];
    tok.kind      = TOK_MID;
    unique case (state)
      FS_IDLE: begin
        if (finish) state_next = FS_DRAIN;
      end
      FS_DRAIN: begin
        push = !full;
        if (run_count == '0) begin
          tok.kind = TOK_EMPTY;
          if (!full) state_next = FS_IDLE;
        end else if (count == '0) begin
          tok.kind     = TOK_TAIL;
          tok.span_end = last_end;
          if (!full) state_next = FS_IDLE;
        end else begin
          tok.kind = (count == run_count) ? TOK_HEAD : TOK_MID;
          span_out = !full;
        end
      end
      default: state_next = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= FS_IDLE;
      count         <= '0;
      total         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        if (can_ins) begin
          count <= count + CW'(1);
          total <= total + TW'(cmd.glyph_width);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (finish) begin
        total         <= '0;
        overflow_seen <= 1'b0;
      end
      if (span_out) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      run_count <= count;
      run_total <= total;
      run_drop  <= overflow_seen;
    end
    if (span_out) last_end <= span_end[0];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_GLYPHS))
    else $error("span count beyond capacity");

endmodule

// File: hdl/tcgb_queue.sv
// ----------------------------------------------------------------------------
// tcgb_queue
// Short first-in first-out queue of tokens between front and back end.
// ----------------------------------------------------------------------------
module tcgb_queue #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         nonempty
);
  import tcgb_pkg::*;

  logic [W-1:0]   entry [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   fill;

  assign full     = (fill == (QAW+1)'(QDEPTH));
  assign nonempty = (fill != '0);
  assign rdata    = entry[rp];

  always_ff @(posedge clk) begin
    if (push) entry[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= wp + QAW'(1);
      if (pop)  rp <= rp + QAW'(1);
      if (push && !pop) fill <= fill + (QAW+1)'(1);
      else if (pop && !push) fill <= fill - (QAW+1)'(1);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from empty queue");

endmodule

// File: hdl/tcgb_back.sv
// ----------------------------------------------------------------------------
// tcgb_back
// Tests each gap against twice the mean glyph width, merges near boundaries
// and emits at most one result per cycle.
// ----------------------------------------------------------------------------
module tcgb_back #(
  parameter int CW = 6,
  parameter int TW = 22
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  output logic                    pop,
  input  tcgb_pkg::tcgb_tok_t     tok,
  input  logic [CW-1:0]           run_count,
  input  logic [TW-1:0]           run_total,
  input  logic [tcgb_pkg::TOLW-1:0] tolerance,
  output logic                    strobe,
  output tcgb_pkg::tcgb_out_t     result
);
  import tcgb_pkg::*;

  localparam int PW = XW + CW;

  logic [EW-1:0]  a_end;
  logic           gap_pos;
  logic [XW-1:0]  gap;
  logic [PW-1:0]  prod;
  logic           pass;
  logic [BW-1:0]  value;

  logic           s1_valid;
  tok_kind_t      s1_kind;
  logic [BW-1:0]  s1_value;
  logic           s1_pass;
  logic           s1_drop;

  logic [BW-1:0]  prev, prev_next, diff;
  logic [IW-1:0]  n, n_next;
  logic           strobe_next;
  tcgb_out_t      result_next;

  assign pop     = valid;
  assign gap_pos = ({1'b0, tok.start} > a_end);
  assign gap     = gap_pos ? (tok.start - a_end[XW-1:0]) : '0;
  assign prod    = PW'(gap) * PW'(run_count);
  assign pass    = gap_pos && (prod > PW'({run_total, 1'b0}));

  always_comb begin
    unique case (tok.kind)
      TOK_EMPTY: value = '0;
      TOK_HEAD:  value = {1'b0, tok.start, 1'b0};
      TOK_MID:   value = BW'(a_end) + BW'(tok.start);
      TOK_TAIL:  value = {tok.span_end, 1'b0};
      default:   value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind  <= tok.kind;
      s1_value <= value;
      s1_pass  <= pass;
      s1_drop  <= tok.dropped;
      if ((tok.kind == TOK_HEAD) || (tok.kind == TOK_MID)) a_end <= tok.span_end;
    end
  end

  assign diff = (s1_value > prev) ? (s1_value - prev) : (prev - s1_value);

  always_comb begin
    strobe_next                = 1'b0;
    prev_next                  = prev;
    n_next                     = n;
    result_next.boundary       = s1_value;
    result_next.boundary_index = n;
    result_next.last           = 1'b0;
    result_next.empty_res      = 1'b0;
    result_next.dropped        = s1_drop;
    if (s1_valid) begin
      unique case (s1_kind)
        TOK_EMPTY: begin
          strobe_next                = 1'b1;
          result_next.boundary       = '0;
          result_next.boundary_index = '0;
          result_next.last           = 1'b1;
          result_next.empty_res      = 1'b1;
        end
        TOK_HEAD: begin
          strobe_next                = 1'b1;
          result_next.boundary_index = '0;
          prev_next                  = s1_value;
          n_next                     = IW'(1);
        end
        TOK_MID: begin
          if (s1_pass && (diff > BW'({tolerance, 1'b0})) &&
              (n < IW'(MAX_OUT - 1))) begin
            strobe_next = 1'b1;
            prev_next   = s1_value;
            n_next      = n + IW'(1);
          end
        end
        TOK_TAIL: begin
          strobe_next      = 1'b1;
          result_next.last = 1'b1;
        end
        default: strobe_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    prev   <= prev_next;
    n      <= n_next;
  end

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    strobe && result.empty_res |-> result.last && (result.boundary_index == '0) &&
    (result.boundary == '0))
    else $error("malformed empty result");

  a_head_first: assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_kind == TOK_HEAD) |=> strobe && (result.boundary_index == '0) &&
    !result.last)
    else $error("run head not emitted as first boundary");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the column gap boundary finder. An initial block
// queues glyph loads and finish commands: a short directed set, then random
// runs of column-shaped lines and noise under several tolerance settings.
// A clocked driver feeds the queue under random idling. A behavioral
// predictor updates a sorted span store on each accepted item and queues the
// boundaries a finish should yield. A clocked monitor checks every strobed
// result against the oldest queued boundary.
// ----------------------------------------------------------------------------
module tb;
  import tcgb_pkg::*;

  localparam int GLYPH_CAP = 63;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  tcgb_in_t        cmd = '0;
  logic            cfg_wr = 1'b0;
  logic [TOLW-1:0] cfg_wdata = '0;
  logic            strobe;
  tcgb_out_t       result;

  tcgb_in_t        item_q[$];
  tcgb_out_t       boundaries_due[$];
  int unsigned     idle_pct = 38;
  bit              failed = 1'b0;

  logic [XW-1:0]   glyph_lo[GLYPH_CAP];
  logic [EW-1:0]   glyph_hi[GLYPH_CAP];
  int              glyph_cnt = 0;
  longint unsigned advance_sum = 0;
  logic            lost_glyphs = 1'b0;
  logic [TOLW-1:0] tol_model = TOL_RESET;

  text_column_gap_boundary_finder #(
    .MAX_GLYPHS(GLYPH_CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .cfg_wr(cfg_wr),
    .cfg_wdata(cfg_wdata),
    .strobe(strobe),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_boundary(longint unsigned pos, int idx, bit is_last,
                                        bit is_empty);
    tcgb_out_t r;
    r.boundary       = pos[BW-1:0];
    r.boundary_index = idx[IW-1:0];
    r.last           = is_last;
    r.empty_res      = is_empty;
    r.dropped        = lost_glyphs;
    boundaries_due = {boundaries_due, r};
  endfunction

  function automatic void predict_boundaries(tcgb_in_t it);
    logic [EW-1:0]   e;
    int              pos;
    int              n;
    longint unsigned prev;
    longint unsigned gap;
    longint unsigned mid;
    longint unsigned diff;
    longint unsigned tol2;
    if (it.func == FUNC_LOAD) begin
      e = {1'b0, it.glyph_x} + it.glyph_width;
      if (glyph_cnt >= GLYPH_CAP) begin
        lost_glyphs = 1'b1;
      end else begin
        pos = glyph_cnt;
        for (int j = 0; j < glyph_cnt; j++) begin
          if (it.glyph_x < glyph_lo[j] || (it.glyph_x == glyph_lo[j] && e < glyph_hi[j])) begin
            pos = j;
            break;
          end
        end
        for (int j = glyph_cnt; j > pos; j--) begin
          glyph_lo[j] = glyph_lo[j-1];
          glyph_hi[j] = glyph_hi[j-1];
        end
        glyph_lo[pos] = it.glyph_x;
        glyph_hi[pos] = e;
        glyph_cnt++;
        advance_sum += it.glyph_width;
      end
    end else begin
      if (glyph_cnt == 0) begin
        push_boundary(0, 0, 1'b1, 1'b1);
      end else begin
        tol2 = longint'(tol_model) * 2;
        n = 0;
        prev = longint'(glyph_lo[0]) * 2;
        push_boundary(prev, n, 1'b0, 1'b0);
        n++;
        for (int i = 1; i < glyph_cnt && n < MAX_OUT - 1; i++) begin
          if (glyph_lo[i] > glyph_hi[i-1]) begin
            gap = longint'(glyph_lo[i]) - longint'(glyph_hi[i-1]);
            if (gap * glyph_cnt > advance_sum * 2) begin
              mid = longint'(glyph_hi[i-1]) + longint'(glyph_lo[i]);
              diff = (mid > prev) ? mid - prev : prev - mid;
              if (diff > tol2) begin
                push_boundary(mid, n, 1'b0, 1'b0);
                n++;
                prev = mid;
              end
            end
          end
        end
        push_boundary(longint'(glyph_hi[glyph_cnt-1]) * 2, n, 1'b1, 1'b0);
      end
      glyph_cnt = 0;
      advance_sum = 0;
      lost_glyphs = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_boundaries(cmd);
        void'(item_q.pop_front());
      end
      if (!(start && busy)) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          cmd   <= item_q[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tcgb_out_t exp_r;
    bit        bad;
    bad = 1'b0;
    if (!rst && strobe) begin
      if (boundaries_due.size() == 0) begin
        $display("%0t unexpected result: expected none, got boundary %0d index %0d",
                 $time, result.boundary, result.boundary_index);
        bad = 1'b1;
      end else begin
        exp_r = boundaries_due.pop_front();
        if (result.boundary !== exp_r.boundary) begin
          $display("%0t boundary: expected %0d, got %0d", $time, exp_r.boundary,
                   result.boundary);
          bad = 1'b1;
        end
        if (result.boundary_index !== exp_r.boundary_index) begin
          $display("%0t boundary_index: expected %0d, got %0d", $time,
                   exp_r.boundary_index, result.boundary_index);
          bad = 1'b1;
        end
        if (result.last !== exp_r.last) begin
          $display("%0t last: expected %0b, got %0b", $time, exp_r.last, result.last);
          bad = 1'b1;
        end
        if (result.empty_res !== exp_r.empty_res) begin
          $display("%0t empty_res: expected %0b, got %0b", $time, exp_r.empty_res,
                   result.empty_res);
          bad = 1'b1;
        end
        if (result.dropped !== exp_r.dropped) begin
          $display("%0t dropped: expected %0b, got %0b", $time, exp_r.dropped,
                   result.dropped);
          bad = 1'b1;
        end
      end
    end
    if (bad) failed <= 1'b1;
  end

  task automatic queue_item(logic f, logic [XW-1:0] x, logic [WW-1:0] w);
    tcgb_in_t it;
    it.func        = f;
    it.glyph_x     = x;
    it.glyph_width = w;
    item_q = {item_q, it};
  endtask

  task automatic wait_idle();
    while (item_q.size() != 0 || boundaries_due.size() != 0 || start || busy)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [TOLW-1:0] v);
    wait_idle();
    cfg_wr    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr    <= 1'b0;
    tol_model = v;
    @(posedge clk);
  endtask

  // queue one line of glyphs and its finish; return the items that count
  task automatic queue_line(output int counted);
    int          n;
    int          ncols;
    int          pitch;
    int          base;
    int          col;
    bit          noisy;
    int unsigned x;
    int unsigned w;
    n = $urandom_range(0, 99);
    if (n < 5)
      n = $urandom_range(64, 70);
    else if (n < 13)
      n = $urandom_range(40, 63);
    else
      n = $urandom_range(0, 12);
    noisy = ($urandom_range(0, 99) < 30);
    ncols = $urandom_range(1, 4);
    pitch = $urandom_range(600, 200000);
    base  = $urandom_range(0, 200000);
    for (int k = 0; k < n; k++) begin
      if (noisy) begin
        x = $urandom_range(0, 20'hFFFFF);
        w = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, 64);
      end else begin
        col = $urandom_range(0, ncols - 1);
        x = base + col * pitch + $urandom_range(0, 600);
        w = $urandom_range(0, 160);
      end
      queue_item(FUNC_LOAD, x[XW-1:0], w[WW-1:0]);
    end
    queue_item(FUNC_FINISH, XW'($urandom_range(0, 20'hFFFFF)),
               WW'($urandom_range(0, 16'hFFFF)));
    counted = ((n > GLYPH_CAP) ? GLYPH_CAP : n) + 1;
  endtask

  initial begin
    int               got;
    int               total;
    logic [TOLW-1:0]  tol_plan[6];
    int unsigned      idle_plan[6];
    tol_plan  = '{12'd0, 12'hFFF, 12'd0, 12'd1, 12'd0, 12'hFFF};
    idle_plan = '{38, 38, 79, 79, 0, 0};
    tol_plan[2] = TOLW'($urandom_range(2, 4094));
    tol_plan[4] = TOLW'($urandom_range(2, 300));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty store, zero-width glyph, extreme fields
    queue_item(FUNC_FINISH, 20'hFFFFF, 16'hFFFF);
    queue_item(FUNC_LOAD, 20'd0, 16'd0);
    queue_item(FUNC_FINISH, 20'd0, 16'd0);
    queue_item(FUNC_LOAD, 20'hFFFFF, 16'hFFFF);
    queue_item(FUNC_LOAD, 20'd0, 16'd1);
    queue_item(FUNC_FINISH, 20'd0, 16'd0);
    // touching and overlapping spans, then a far one
    queue_item(FUNC_LOAD, 20'd100, 16'd50);
    queue_item(FUNC_LOAD, 20'd150, 16'd10);
    queue_item(FUNC_LOAD, 20'd120, 16'd40);
    queue_item(FUNC_LOAD, 20'd5000, 16'd10);
    queue_item(FUNC_FINISH, 20'd0, 16'd0);
    // midpoint within tolerance of the first boundary
    queue_item(FUNC_LOAD, 20'd200, 16'd0);
    queue_item(FUNC_LOAD, 20'd110, 16'd0);
    queue_item(FUNC_LOAD, 20'd100, 16'd0);
    queue_item(FUNC_FINISH, 20'd0, 16'd0);
    // equal starts sort by end
    queue_item(FUNC_LOAD, 20'd300, 16'd20);
    queue_item(FUNC_LOAD, 20'd300, 16'd10);
    queue_item(FUNC_LOAD, 20'd300, 16'd20);
    queue_item(FUNC_LOAD, 20'd50, 16'd5);
    queue_item(FUNC_FINISH, 20'd0, 16'd0);

    for (int b = 0; b < 6; b++) begin
      set_tolerance(tol_plan[b]);
      idle_pct = idle_plan[b];
      total = 0;
      while (total < 40) begin
        queue_line(got);
        total += got;
      end
    end

    wait_idle();
    if (failed)
      $display("Verification failed");
    else
      $display("Verification passed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
